@@ rtl/rrpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrpt_pkg
// Types and constants shared by the respiration rate peak tracker modules.
// ----------------------------------------------------------------------------
package rrpt_pkg;

   localparam int RAW_W      = 24;
   localparam int TIME_W     = 32;
   localparam int FILT_W     = 40;
   localparam int RATE_W     = 24;
   localparam int DIFF_W     = 25;
   localparam int ALPHA_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 120;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [RATE_W-1:0] RATE_SCALE = 24'd15360000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_IVAL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_RATE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_VLD  = 3'd5;

   // rate event codes
   localparam logic [1:0] EVT_NONE  = 2'd0;
   localparam logic [1:0] EVT_FIRST = 2'd1;
   localparam logic [1:0] EVT_CMP   = 2'd2;

   // trend codes
   localparam logic [1:0] TREND_SAME     = 2'd0;
   localparam logic [1:0] TREND_WORSE    = 2'd1;
   localparam logic [1:0] TREND_IMPROVED = 2'd2;

   typedef struct packed {
      logic signed [RAW_W-1:0] raw_sample;
      logic [TIME_W-1:0]       time_ms;
   } item_type;

   typedef struct packed {
      logic [ALPHA_W-1:0]      alpha;
      logic signed [RAW_W-1:0] peak_threshold;
      logic [15:0]             min_peak_interval_ms;
      logic [15:0]             trend_epsilon;
      logic [RATE_W-1:0]       baseline_rate;
      logic                    baseline_valid;
      logic                    load_rate;
      logic                    load_valid;
   } cfg_type;

endpackage
`default_nettype wire

@@ rtl/respiration_rate_peak_tracker_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// respiration_rate_peak_tracker_top
// Filters pressure samples, detects breathing peaks and reports the rate.
// ----------------------------------------------------------------------------
// Each item gives one result. An item passes S_MUL_LO, S_MUL_HI, S_ADD,
// S_UPD and S_PEAK before its result; the very first item skips the filter
// multiply. An item that closes a peak interval also goes through the
// one-bit-a-cycle restoring divider and S_CMP; a zero interval leaves the
// divider early.
// The filter product is split into two partial products that S_ADD sums.
// A small input queue keeps accepting items while it has room, also while
// the back end works or a result waits to be taken.
module respiration_rate_peak_tracker_top #(
   parameter int QUEUE_DEPTH = rrpt_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // raw_sample[23:0], time_ms[55:24]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [rrpt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // filtered[39:0], peak_found[40], rate_event[42:41], new_rate[66:43],
   // old_rate[90:67], rate_difference[115:91], trend[117:116], zero[119:118]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [rrpt_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [rrpt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rrpt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rrpt_pkg::*;

   cfg_type  cfg;
   item_type q_item;
   logic     q_valid, q_pop;

   rrpt_csr u_csr (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .cfg(cfg)
   );

   rrpt_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_tdata(req_tdata), .q_valid(q_valid),
      .q_item(q_item), .q_pop(q_pop)
   );

   rrpt_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .q_valid(q_valid),
      .q_item(q_item), .q_pop(q_pop), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

endmodule
`default_nettype wire

@@ rtl/rrpt_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrpt_csr
// Configuration registers with write strobes for the baseline loads.
// ----------------------------------------------------------------------------
module rrpt_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [rrpt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rrpt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output rrpt_pkg::cfg_type                      cfg
);
   import rrpt_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in            = cfg_ff;
      cfg_in.load_rate  = 1'b0;
      cfg_in.load_valid = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_ALPHA:     cfg_in.alpha = csr_wdata[ALPHA_W-1:0];
            CSR_THRESHOLD: cfg_in.peak_threshold = csr_wdata[RAW_W-1:0];
            CSR_MIN_IVAL:  cfg_in.min_peak_interval_ms = csr_wdata[15:0];
            CSR_EPSILON:   cfg_in.trend_epsilon = csr_wdata[15:0];
            CSR_BASE_RATE: begin
               cfg_in.baseline_rate = csr_wdata[RATE_W-1:0];
               cfg_in.load_rate     = 1'b1;
            end
            CSR_BASE_VLD: begin
               cfg_in.baseline_valid = csr_wdata[0];
               cfg_in.load_valid     = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha                <= 16'd5243;
         cfg_ff.peak_threshold       <= 24'sd5000;
         cfg_ff.min_peak_interval_ms <= 16'd1500;
         cfg_ff.trend_epsilon        <= 16'd13;
         cfg_ff.baseline_rate        <= '0;
         cfg_ff.baseline_valid       <= 1'b0;
         cfg_ff.load_rate            <= 1'b0;
         cfg_ff.load_valid           <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ rtl/rrpt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrpt_front
// Input side: accepts items and queues them for the processing back end.
// ----------------------------------------------------------------------------
module rrpt_front #(
   parameter int QUEUE_DEPTH = rrpt_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [rrpt_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   q_valid,
   output rrpt_pkg::item_type                     q_item,
   input  wire logic                              q_pop
);
   import rrpt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign req_tready = (count_ff != FULL_CNT);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_item     = mem_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff].raw_sample <= req_tdata[RAW_W-1:0];
         mem_ff[wr_ptr_ff].time_ms    <= req_tdata[RAW_W+TIME_W-1:RAW_W];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |=> (count_ff <= CNT_W'(1))) else $error("queue jumped");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (count_ff == FULL_CNT) |-> !push) else $error("push into full queue");

endmodule
`default_nettype wire

@@ rtl/rrpt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrpt_back
// Processing back end: filter update, peak detection, serial rate divide,
// rate comparison and the result register.
// ----------------------------------------------------------------------------
module rrpt_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  rrpt_pkg::cfg_type                      cfg,
   input  wire logic                              q_valid,
   input  rrpt_pkg::item_type                     q_item,
   output logic                                   q_pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [rrpt_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import rrpt_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_MUL_LO = 9'b000000010,
      S_MUL_HI = 9'b000000100,
      S_ADD    = 9'b000001000,
      S_UPD    = 9'b000010000,
      S_PEAK   = 9'b000100000,
      S_DIV    = 9'b001000000,
      S_CMP    = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // held item and work registers
   logic signed [RAW_W-1:0]   raw_ff;
   logic [TIME_W-1:0]         time_ff;
   logic signed [FILT_W:0]    dif_ff;
   logic [39:0]               prod_lo_ff;
   logic signed [33:0]        prod_hi_ff;
   logic signed [40:0]        inc_ff;
   logic [TIME_W-1:0]         ival_ff;
   logic [TIME_W-1:0]         num_ff;
   logic [TIME_W:0]           rem_ff;
   logic [4:0]                step_ff;

   // tracker state
   logic signed [FILT_W-1:0]  filt_ff;
   logic signed [FILT_W-1:0]  prev_ff;
   logic                      first_ff, rising_ff, seen_ff, prior_vld_ff;
   logic [TIME_W-1:0]         last_peak_ff;
   logic [RATE_W-1:0]         prior_ff, latest_ff;

   // result fields
   logic                      found_ff;
   logic [1:0]                event_ff, trend_ff;
   logic [RATE_W-1:0]         old_ff;
   logic signed [DIFF_W-1:0]  diff_ff;

   logic signed [FILT_W-1:0]  raw_q;
   logic signed [56:0]        prod_sum;
   logic signed [56:0]        prod_rnd;
   logic [TIME_W:0]           rem_sh;
   logic [TIME_W:0]           rem_sub;
   logic signed [FILT_W-1:0]  thr_q;
   logic [TIME_W-1:0]         ival;
   logic [RATE_W-1:0]         rate;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [DIFF_W-1:0]  eps;

   assign raw_q    = {raw_ff, 16'd0};
   assign thr_q    = {cfg.peak_threshold, 16'd0};
   assign ival     = time_ff - last_peak_ff;
   assign prod_sum = ({{23{prod_hi_ff[33]}}, prod_hi_ff} <<< 24)
                     + $signed({17'd0, prod_lo_ff});
   assign prod_rnd = prod_sum + 57'sd32768;
   assign rem_sh   = {rem_ff[TIME_W-1:0], num_ff[TIME_W-1]};
   assign rem_sub  = rem_sh - {1'b0, ival_ff};
   assign rate     = (num_ff > {8'd0, RATE_SCALE}) ? RATE_SCALE : num_ff[RATE_W-1:0];
   assign diff     = $signed({1'b0, rate}) - $signed({1'b0, prior_ff});
   assign eps      = $signed({9'd0, cfg.trend_epsilon});

   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {2'b00, trend_ff, diff_ff, old_ff, latest_ff, event_ff,
                        found_ff, filt_ff};

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (q_valid) state_in = S_MUL_LO;
         S_MUL_LO: state_in = first_ff ? S_UPD : S_MUL_HI;
         S_MUL_HI: state_in = S_ADD;
         S_ADD:    state_in = S_UPD;
         S_UPD:    state_in = S_PEAK;
         S_PEAK: begin
            state_in = S_OUT;
            if ((filt_ff < prev_ff) && rising_ff && (prev_ff > thr_q) && seen_ff &&
                (ival >= {16'd0, cfg.min_peak_interval_ms}))
               state_in = S_DIV;
         end
         S_DIV:    if (step_ff == 5'd31 || ival_ff == '0) state_in = S_CMP;
         S_CMP:    state_in = S_OUT;
         S_OUT:    if (rsp_tready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               raw_ff  <= q_item.raw_sample;
               time_ff <= q_item.time_ms;
            end
         end
         S_MUL_LO: begin
            dif_ff <= {raw_q[FILT_W-1], raw_q} - {filt_ff[FILT_W-1], filt_ff};
         end
         S_MUL_HI: begin
            prod_lo_ff <= cfg.alpha * dif_ff[23:0];
            prod_hi_ff <= $signed({1'b0, cfg.alpha}) * $signed(dif_ff[40:24]);
         end
         S_ADD: inc_ff <= prod_rnd[56:16];
         default: ;
      endcase
   end

   // tracker state and result fields
   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff      <= '0;
         prev_ff      <= '0;
         first_ff     <= 1'b1;
         rising_ff    <= 1'b0;
         seen_ff      <= 1'b0;
         last_peak_ff <= '0;
         prior_ff     <= '0;
         prior_vld_ff <= 1'b0;
         latest_ff    <= '0;
         found_ff     <= 1'b0;
         event_ff     <= EVT_NONE;
         trend_ff     <= TREND_SAME;
         old_ff       <= '0;
         diff_ff      <= '0;
         step_ff      <= '0;
      end else begin
         if (cfg.load_rate)  prior_ff     <= cfg.baseline_rate;
         if (cfg.load_valid) prior_vld_ff <= cfg.baseline_valid;
         case (state_ff)
            S_UPD: begin
               found_ff <= 1'b0;
               event_ff <= EVT_NONE;
               trend_ff <= TREND_SAME;
               old_ff   <= '0;
               diff_ff  <= '0;
               if (first_ff) begin
                  filt_ff  <= raw_q;
                  first_ff <= 1'b0;
               end else begin
                  filt_ff <= filt_ff + inc_ff[FILT_W-1:0];
               end
            end
            S_PEAK: begin
               prev_ff <= filt_ff;
               ival_ff <= ival;
               num_ff  <= {8'd0, RATE_SCALE} + {1'b0, ival[TIME_W-1:1]};
               rem_ff  <= '0;
               step_ff <= '0;
               if (filt_ff > prev_ff) begin
                  rising_ff <= 1'b1;
               end else if (rising_ff && filt_ff < prev_ff) begin
                  rising_ff <= 1'b0;
                  if (prev_ff > thr_q &&
                      (!seen_ff || ival >= {16'd0, cfg.min_peak_interval_ms})) begin
                     found_ff     <= 1'b1;
                     last_peak_ff <= time_ff;
                     seen_ff      <= 1'b1;
                  end
               end
            end
            S_DIV: begin
               // restoring divide, one quotient bit a cycle
               step_ff <= step_ff + 1'b1;
               if (ival_ff == '0) begin
                  num_ff <= {8'd0, RATE_SCALE};
               end else if (!rem_sub[TIME_W]) begin
                  rem_ff <= rem_sub;
                  num_ff <= {num_ff[TIME_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  num_ff <= {num_ff[TIME_W-2:0], 1'b0};
               end
            end
            S_CMP: begin
               latest_ff <= rate;
               prior_ff  <= rate;
               if (!prior_vld_ff) begin
                  prior_vld_ff <= 1'b1;
                  event_ff     <= EVT_FIRST;
                  old_ff       <= rate;
               end else begin
                  event_ff <= EVT_CMP;
                  old_ff   <= prior_ff;
                  diff_ff  <= diff;
                  if (diff > eps)       trend_ff <= TREND_WORSE;
                  else if (diff < -eps) trend_ff <= TREND_IMPROVED;
               end
            end
            default: ;
         endcase
      end
   end

   a_event_has_peak: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && event_ff != EVT_NONE) |-> found_ff)
      else $error("rate event without peak");
   a_first_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && event_ff == EVT_FIRST) |-> (diff_ff == '0 && old_ff == latest_ff))
      else $error("first rate fields wrong");
   a_rate_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |=> (latest_ff <= RATE_SCALE))
      else $error("rate above scale");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(filt_ff)))
      else $error("result changed while waiting");

endmodule
`default_nettype wire
